// ===== hdl/urfl_pkg.sv =====
// Package for the UART register file: command codes, register offsets,
// bit positions, transaction types and the modem status update function.
// No dependencies.
package urfl_pkg;

    typedef enum logic [2:0] {
        CMD_READ    = 3'd0,
        CMD_WRITE   = 3'd1,
        CMD_TX_DONE = 3'd2,
        CMD_RX_BYTE = 3'd3,
        CMD_MODEM   = 3'd4
    } cmd_t;

    localparam logic [2:0] OFS_RBR_THR = 3'd0;
    localparam logic [2:0] OFS_IER     = 3'd1;
    localparam logic [2:0] OFS_IIR     = 3'd2;
    localparam logic [2:0] OFS_LCR     = 3'd3;
    localparam logic [2:0] OFS_MCR     = 3'd4;
    localparam logic [2:0] OFS_LSR     = 3'd5;
    localparam logic [2:0] OFS_MSR     = 3'd6;
    localparam logic [2:0] OFS_SCR     = 3'd7;

    // line status bits
    localparam int LS_DR   = 0;
    localparam int LS_THRE = 5;
    localparam int LS_TEMT = 6;
    localparam logic [7:0] LS_ERRS  = 8'h1E;
    localparam logic [7:0] LS_RMASK = 8'h7F;
    localparam logic [7:0] LS_RESET = 8'h60;

    // modem status bits
    localparam int MS_DCTS = 0;
    localparam int MS_DDSR = 1;
    localparam int MS_TERI = 2;
    localparam int MS_DDCD = 3;
    localparam int MS_CTS  = 4;
    localparam int MS_DSR  = 5;
    localparam int MS_RI   = 6;
    localparam int MS_DCD  = 7;
    localparam logic [7:0] MS_DELTAS = 8'h0F;

    // modem control bits
    localparam int MC_DTR  = 0;
    localparam int MC_RTS  = 1;
    localparam int MC_OUT1 = 2;
    localparam int MC_OUT2 = 3;
    localparam int MC_LOOP = 4;

    localparam int LC_DLAB = 7;

    localparam logic [7:0] IIR_RESET = 8'h01;

    typedef struct packed {
        cmd_t       cmd;
        logic [2:0] reg_offset;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_start;
        logic [7:0] tx_byte;
        logic       tx_looped;
    } result_t;

    // new levels in bits 7..4; sticky change flags, trailing-edge RI
    function automatic logic [7:0] modem_update(input logic [7:0] old_ms,
                                                input logic [7:0] levels);
        logic [7:0] nv;
        nv = {levels[7:4], old_ms[3:0]};
        if (old_ms[MS_CTS] != nv[MS_CTS]) nv[MS_DCTS] = 1'b1;
        if (old_ms[MS_DSR] != nv[MS_DSR]) nv[MS_DDSR] = 1'b1;
        if (old_ms[MS_DCD] != nv[MS_DCD]) nv[MS_DDCD] = 1'b1;
        if (old_ms[MS_RI] && !nv[MS_RI]) nv[MS_TERI] = 1'b1;
        return nv;
    endfunction

endpackage

// ===== hdl/urfl_core.sv =====
// Register state of the UART and the single-pass update for one transaction.
// Depends on urfl_pkg.
module urfl_core
    import urfl_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  item_t   item,
    output result_t result
);

    logic [7:0]  rbr_reg, rbr_next;
    logic [7:0]  thr_reg, thr_next;
    logic [7:0]  ier_reg, ier_next;
    logic [7:0]  lcr_reg, lcr_next;
    logic [7:0]  mcr_reg, mcr_next;
    logic [7:0]  lsr_reg, lsr_next;
    logic [7:0]  msr_reg, msr_next;
    logic [7:0]  scr_reg, scr_next;
    logic [7:0]  iir_reg;
    logic [15:0] div_reg, div_next;

    logic       loop_on;
    logic       dlab;
    logic [7:0] lb_levels;

    assign loop_on   = mcr_reg[MC_LOOP];
    assign dlab      = lcr_reg[LC_DLAB];
    assign lb_levels = {item.data[MC_OUT2], item.data[MC_OUT1],
                        item.data[MC_DTR], item.data[MC_RTS], 4'b0000};

    always_comb
    begin
        rbr_next = rbr_reg;
        thr_next = thr_reg;
        ier_next = ier_reg;
        lcr_next = lcr_reg;
        mcr_next = mcr_reg;
        lsr_next = lsr_reg;
        msr_next = msr_reg;
        scr_next = scr_reg;
        div_next = div_reg;
        result   = '0;

        unique case (item.cmd)
            CMD_READ:
            begin
                unique case (item.reg_offset)
                    OFS_RBR_THR:
                    begin
                        if (dlab)
                        begin
                            result.read_data = div_reg[7:0];
                        end
                        else
                        begin
                            result.read_data = rbr_reg;
                            lsr_next[LS_DR]  = 1'b0;
                        end
                    end
                    OFS_IER:  result.read_data = dlab ? div_reg[15:8] : ier_reg;
                    OFS_IIR:  result.read_data = iir_reg;
                    OFS_LCR:  result.read_data = lcr_reg;
                    OFS_MCR:  result.read_data = mcr_reg;
                    OFS_LSR:
                    begin
                        result.read_data = lsr_reg & LS_RMASK;
                        lsr_next         = lsr_reg & ~LS_ERRS;
                    end
                    OFS_MSR:
                    begin
                        result.read_data = msr_reg;
                        msr_next         = msr_reg & ~MS_DELTAS;
                    end
                    default:  result.read_data = scr_reg;
                endcase
            end
            CMD_WRITE:
            begin
                unique case (item.reg_offset)
                    OFS_RBR_THR:
                    begin
                        if (dlab)
                        begin
                            div_next[7:0] = item.data;
                        end
                        else
                        begin
                            thr_next          = item.data;
                            lsr_next[LS_THRE] = 1'b0;
                            lsr_next[LS_TEMT] = 1'b0;
                            result.tx_start   = 1'b1;
                            result.tx_byte    = item.data;
                            result.tx_looped  = loop_on;
                        end
                    end
                    OFS_IER:
                    begin
                        if (dlab)
                            div_next[15:8] = item.data;
                        else
                            ier_next = item.data;
                    end
                    OFS_LCR: lcr_next = item.data;
                    OFS_MCR:
                    begin
                        mcr_next = item.data;
                        if (item.data[MC_LOOP])
                            msr_next = modem_update(msr_reg, lb_levels);
                    end
                    OFS_SCR: scr_next = item.data;
                    default: ;
                endcase
            end
            CMD_TX_DONE:
            begin
                if (loop_on)
                begin
                    rbr_next        = thr_reg;
                    lsr_next[LS_DR] = 1'b1;
                end
                lsr_next[LS_THRE] = 1'b1;
                lsr_next[LS_TEMT] = 1'b1;
            end
            CMD_RX_BYTE:
            begin
                if (!loop_on)
                begin
                    rbr_next        = item.data;
                    lsr_next[LS_DR] = 1'b1;
                end
            end
            CMD_MODEM:
            begin
                if (!loop_on)
                    msr_next = modem_update(msr_reg, item.data);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rbr_reg <= '0;
            thr_reg <= '0;
            ier_reg <= '0;
            lcr_reg <= '0;
            mcr_reg <= '0;
            lsr_reg <= LS_RESET;
            msr_reg <= '0;
            scr_reg <= '0;
            iir_reg <= IIR_RESET;
            div_reg <= '0;
        end
        else if (fire)
        begin
            rbr_reg <= rbr_next;
            thr_reg <= thr_next;
            ier_reg <= ier_next;
            lcr_reg <= lcr_next;
            mcr_reg <= mcr_next;
            lsr_reg <= lsr_next;
            msr_reg <= msr_next;
            scr_reg <= scr_next;
            div_reg <= div_next;
        end
    end

endmodule

// ===== hdl/uart_register_file_with_loopback.sv =====
// Top level of the UART register file: input register, register core and
// result register on stream interfaces. Depends on urfl_pkg and urfl_core.
// A transaction is held in the input register, then its result in the result register.
// Throughput: one transaction per cycle while the output is not stalled; set by the single-pass core update.
// Reset: rst_n clears valids and core registers; LSR resets to 0x60, IIR to 0x01.
module uart_register_file_with_loopback
    import urfl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data
    input  logic [7:0] s_axis_tuser,   // [2:0] cmd, [5:3] reg_offset, [7:6] zero
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [7:0] read_data, [15:8] tx_byte
    output logic [7:0] m_axis_tuser    // [0] tx_start, [1] tx_looped, [7:2] zero
);

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_result_reg;
    result_t core_result;
    logic    advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_item_reg.cmd        <= cmd_t'(s_axis_tuser[2:0]);
            in_item_reg.reg_offset <= s_axis_tuser[5:3];
            in_item_reg.data       <= s_axis_tdata;
        end
    end

    urfl_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (in_item_reg),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_result_reg <= core_result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_result_reg.tx_byte, out_result_reg.read_data};
    assign m_axis_tuser  = {6'b000000, out_result_reg.tx_looped, out_result_reg.tx_start};

    // looped flag only comes with a transmit start
    a_looped_needs_start: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser[0] || !m_axis_tuser[1]))
        else $error("tx_looped without tx_start");

    // a transmit start never carries read data
    a_start_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[7:0] == 8'h00))
        else $error("read_data nonzero on transmit start");

    // full input stage with stalled output must block new transactions
    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while both stages full");

    // a held result stays put while stalled
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(out_result_reg))
        else $error("stalled result changed");

endmodule
